// ----- hw/rtl/assert_macros.svh -----
// assert_macros.svh: concurrent assertion shorthands for the RTL in this folder.
// No dependencies; clock and active-low reset are passed by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ILA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ILA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ----- hw/rtl/ila_pkg.sv -----
// ila_pkg: action and result codes plus the scan status type.
// No dependencies; used by ila_scan and interrupt_line_aggregator_top.
package ila_pkg;

    // Action codes carried by the input item
    localparam logic [2:0] ACT_ENABLE   = 3'd0;
    localparam logic [2:0] ACT_DISABLE  = 3'd1;
    localparam logic [2:0] ACT_ANY_PEND = 3'd2;
    localparam logic [2:0] ACT_LINE_PEND = 3'd3;
    localparam logic [2:0] ACT_DISPATCH = 3'd4;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // Handler table index width
    localparam int TIDX_W = 12;

    // Status of the dispatch scanner
    typedef struct packed {
        logic active;   // hits remain to be walked
        logic hit;      // current line is pending and enabled
        logic last;     // current line is the final hit
    } scan_stat_t;

endpackage

// ----- hw/rtl/ila_scan.sv -----
// ila_scan: walks the dispatch hit vector one line per cycle while advance is high, lowest first.
// Depends on ila_pkg (scan_stat_t).
module ila_scan
    import ila_pkg::*;
#(
    parameter int LINES = 32,
    parameter int LW    = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LINES-1:0] hits_in,
    input  logic             advance,
    output scan_stat_t       stat,
    output logic [LW-1:0]    line_idx
);

    logic [LINES-1:0] hits_reg;
    logic [LINES-1:0] hits_next;
    logic [LW-1:0]    line_reg;
    logic [LW-1:0]    line_next;

    // Load on start, otherwise shift one line per advance
    always_comb
    begin
        hits_next = hits_reg;
        line_next = line_reg;
        if (start)
        begin
            hits_next = hits_in;
            line_next = '0;
        end
        else if (advance)
        begin
            hits_next = hits_reg >> 1;
            line_next = LW'(line_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
            line_reg <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
            line_reg <= line_next;
        end
    end

    // Status toward the sequencer
    assign stat.active = (hits_reg != '0);
    assign stat.hit    = hits_reg[0];
    assign stat.last   = ((hits_reg >> 1) == '0);
    assign line_idx    = line_reg;

endmodule

// ----- hw/rtl/interrupt_line_aggregator_top.sv -----
// interrupt_line_aggregator_top: second-level interrupt aggregator, top level.
// Enable, disable and queries: one result in the cycle after the transfer; next item next cycle.
// Dispatch: one line per cycle from line 0 up to the highest hit; the entry for each hit line
// is formed in the output register, and the next item is taken only once the scan is done.
// Output stalls hold both; a dispatch with no hits gives no result. Reset (async, active
// low) clears mask, parent enable, table base and output valid. Needs ila_pkg, ila_scan.
`include "assert_macros.svh"

module interrupt_line_aggregator_top
    import ila_pkg::*;
#(
    parameter int LINES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TIDX_W-1:0] cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [5:0]        line_index,
    input  logic [31:0]       status_word,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic              pending,
    output logic [TIDX_W-1:0] table_index,
    output logic              parent_on,
    output logic              last
);

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

    logic [TIDX_W-1:0] base_reg;
    logic [LINES-1:0]  mask_reg;
    logic [LINES-1:0]  mask_next;
    logic              parent_reg;
    logic              parent_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              kind_reg;
    logic              kind_next;
    logic              pend_reg;
    logic              pend_next;
    logic [TIDX_W-1:0] tidx_reg;
    logic [TIDX_W-1:0] tidx_next;
    logic              par_out_reg;
    logic              par_out_next;
    logic              last_reg;
    logic              last_next;

    logic              out_free;
    logic              in_xfer;
    logic              line_ok;
    logic [LINES-1:0]  line_bit;
    logic [LINES-1:0]  status_lines;
    logic [LINES-1:0]  dispatch_hits;
    logic              start;
    logic              advance;
    logic              emit;
    logic              reply_pend;
    scan_stat_t        stat;
    logic [LW-1:0]     scan_line;

    // Handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !stat.active && out_free;
    assign in_xfer   = in_valid && in_ready;

    // Line decode
    assign line_ok       = ({1'b0, line_index} < 7'(LINES));
    assign line_bit      = line_ok ? (LINES'(1) << line_index[LW-1:0]) : '0;
    assign status_lines  = status_word[LINES-1:0];
    assign dispatch_hits = status_lines & mask_reg;

    // Scanner control
    assign start   = in_xfer && (action == ACT_DISPATCH);
    assign emit    = stat.active && stat.hit && out_free;
    assign advance = stat.active && (!stat.hit || out_free);

    ila_scan #(
        .LINES (LINES),
        .LW    (LW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .hits_in  (dispatch_hits),
        .advance  (advance),
        .stat     (stat),
        .line_idx (scan_line)
    );

    // State update and result formation
    always_comb
    begin
        mask_next      = mask_reg;
        parent_next    = parent_reg;
        reply_pend     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        pend_next      = pend_reg;
        tidx_next      = tidx_reg;
        par_out_next   = par_out_reg;
        last_next      = last_reg;

        if (in_xfer)
        begin
            case (action)
                ACT_ENABLE:
                begin
                    if (line_ok)
                    begin
                        mask_next   = mask_reg | line_bit;
                        parent_next = 1'b1;
                    end
                end
                ACT_DISABLE:
                begin
                    if (line_ok)
                    begin
                        mask_next = mask_reg & ~line_bit;
                        if (mask_next == '0)
                        begin
                            parent_next = 1'b0;
                        end
                    end
                end
                ACT_ANY_PEND:  reply_pend = (dispatch_hits != '0);
                ACT_LINE_PEND: reply_pend = ((dispatch_hits & line_bit) != '0);
                ACT_DISPATCH:  reply_pend = 1'b0;
                default:       reply_pend = 1'b0;
            endcase

            if (action != ACT_DISPATCH)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_REPLY;
                pend_next      = reply_pend;
                tidx_next      = '0;
                par_out_next   = parent_next;
                last_next      = 1'b1;
            end
        end
        else if (emit)
        begin
            // dispatch entry: base plus line, wrapping in 12 bits
            out_valid_next = 1'b1;
            kind_next      = KIND_ENTRY;
            pend_next      = 1'b1;
            tidx_next      = base_reg + TIDX_W'(scan_line);
            par_out_next   = parent_reg;
            last_next      = stat.last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            mask_reg      <= '0;
            parent_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            mask_reg      <= mask_next;
            parent_reg    <= parent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        pend_reg    <= pend_next;
        tidx_reg    <= tidx_next;
        par_out_reg <= par_out_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pending     = pend_reg;
    assign table_index = tidx_reg;
    assign parent_on   = par_out_reg;
    assign last        = last_reg;

    // Assertions
    `ILA_ASSERT_NXT(a_dispatch_starts_scan, clk, rst_n, start && (dispatch_hits != '0), stat.active)
    `ILA_ASSERT_NXT(a_last_entry_ends_scan, clk, rst_n, emit && stat.last, !stat.active)
    `ILA_ASSERT_IMP(a_mask_implies_parent, clk, rst_n, mask_reg != '0, parent_reg)
    `ILA_ASSERT_NXT(a_reply_is_last, clk, rst_n, in_xfer && (action != ACT_DISPATCH), out_valid_reg && last_reg)

endmodule
